### rtl/stu_pkg.sv
// Shared types, token kind codes, character constants and helper functions of the tokenizer.
package stu_pkg;

  localparam int unsigned POSITION_BITS_DEF   = 24;
  localparam int unsigned LONGEST_KEYWORD_DEF = 6;
  localparam int unsigned KW_MAX_LEN          = 6;

  localparam int unsigned KIND_W  = 6;
  localparam int unsigned FIELD_W = 24;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;
  localparam int unsigned MAX_PUSH   = 3;

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [FIELD_W-1:0] field_t;

  // Token kinds
  localparam kind_t KIND_LPAREN     = 6'd0;
  localparam kind_t KIND_RPAREN     = 6'd1;
  localparam kind_t KIND_LBRACE     = 6'd2;
  localparam kind_t KIND_RBRACE     = 6'd3;
  localparam kind_t KIND_COMMA      = 6'd4;
  localparam kind_t KIND_DOT        = 6'd5;
  localparam kind_t KIND_MINUS      = 6'd6;
  localparam kind_t KIND_PLUS       = 6'd7;
  localparam kind_t KIND_SEMICOLON  = 6'd8;
  localparam kind_t KIND_SLASH      = 6'd9;
  localparam kind_t KIND_STAR       = 6'd10;
  localparam kind_t KIND_BANG       = 6'd11;
  localparam kind_t KIND_BANG_EQ    = 6'd12;
  localparam kind_t KIND_EQUAL      = 6'd13;
  localparam kind_t KIND_EQUAL_EQ   = 6'd14;
  localparam kind_t KIND_GREATER    = 6'd15;
  localparam kind_t KIND_GREATER_EQ = 6'd16;
  localparam kind_t KIND_LESS       = 6'd17;
  localparam kind_t KIND_LESS_EQ    = 6'd18;
  localparam kind_t KIND_IDENT      = 6'd19;
  localparam kind_t KIND_STRING     = 6'd20;
  localparam kind_t KIND_NUMBER     = 6'd21;
  localparam kind_t KIND_KW_CLASS   = 6'd23;
  localparam kind_t KIND_KW_ELSE    = 6'd24;
  localparam kind_t KIND_KW_FALSE   = 6'd25;
  localparam kind_t KIND_KW_FOR     = 6'd26;
  localparam kind_t KIND_KW_FUN     = 6'd27;
  localparam kind_t KIND_KW_IF      = 6'd28;
  localparam kind_t KIND_KW_NIL     = 6'd29;
  localparam kind_t KIND_KW_PRINT   = 6'd31;
  localparam kind_t KIND_KW_RETURN  = 6'd32;
  localparam kind_t KIND_KW_SUPER   = 6'd33;
  localparam kind_t KIND_KW_THIS    = 6'd34;
  localparam kind_t KIND_KW_TRUE    = 6'd35;
  localparam kind_t KIND_KW_VAR     = 6'd36;
  localparam kind_t KIND_KW_WHILE   = 6'd37;
  localparam kind_t KIND_ERROR      = 6'd38;
  localparam kind_t KIND_EOF        = 6'd39;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Codes of the four characters that may start a two-character operator
  localparam logic [1:0] PAIR_BANG    = 2'd0;
  localparam logic [1:0] PAIR_EQUAL   = 2'd1;
  localparam logic [1:0] PAIR_GREATER = 2'd2;
  localparam logic [1:0] PAIR_LESS    = 2'd3;

  typedef struct packed {
    kind_t  kind;
    field_t start;
    field_t length;
    logic   last;
  } token_t;

  typedef struct packed {
    logic [1:0]  count;
    token_t [MAX_PUSH-1:0] tok;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_US;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL;
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE ||
           c == CH_COMMA || c == CH_DOT || c == CH_MINUS || c == CH_PLUS ||
           c == CH_SEMI || c == CH_STAR;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_COMMA:  k = KIND_COMMA;
      CH_DOT:    k = KIND_DOT;
      CH_MINUS:  k = KIND_MINUS;
      CH_PLUS:   k = KIND_PLUS;
      CH_SEMI:   k = KIND_SEMICOLON;
      default:   k = KIND_STAR;
    endcase
    return k;
  endfunction

  function automatic logic is_pair(input logic [7:0] c);
    return c == CH_BANG || c == CH_EQ || c == CH_GT || c == CH_LESS;
  endfunction

  function automatic logic [1:0] pair_code(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_BANG: p = PAIR_BANG;
      CH_EQ:   p = PAIR_EQUAL;
      CH_GT:   p = PAIR_GREATER;
      default: p = PAIR_LESS;
    endcase
    return p;
  endfunction

  // Kind of the starter alone; the kind with a trailing '=' is one more
  function automatic kind_t pair_kind(input logic [1:0] p);
    kind_t k;
    unique case (p)
      PAIR_BANG:    k = KIND_BANG;
      PAIR_EQUAL:   k = KIND_EQUAL;
      PAIR_GREATER: k = KIND_GREATER;
      default:      k = KIND_LESS;
    endcase
    return k;
  endfunction

  // text holds the first name bytes, first byte in the top bits
  function automatic kind_t kw_kind(input logic [8*KW_MAX_LEN-1:0] text,
                                    input logic [3:0] count);
    kind_t k;
    k = KIND_IDENT;
    case (count)
      4'd2: begin
        if (text[47:32] == "if") k = KIND_KW_IF;
      end
      4'd3: begin
        if (text[47:24] == "nil") k = KIND_KW_NIL;
        else if (text[47:24] == "fun") k = KIND_KW_FUN;
        else if (text[47:24] == "for") k = KIND_KW_FOR;
        else if (text[47:24] == "var") k = KIND_KW_VAR;
      end
      4'd4: begin
        if (text[47:16] == "else") k = KIND_KW_ELSE;
        else if (text[47:16] == "this") k = KIND_KW_THIS;
        else if (text[47:16] == "true") k = KIND_KW_TRUE;
      end
      4'd5: begin
        if (text[47:8] == "print") k = KIND_KW_PRINT;
        else if (text[47:8] == "class") k = KIND_KW_CLASS;
        else if (text[47:8] == "false") k = KIND_KW_FALSE;
        else if (text[47:8] == "super") k = KIND_KW_SUPER;
        else if (text[47:8] == "while") k = KIND_KW_WHILE;
      end
      4'd6: begin
        if (text == "return") k = KIND_KW_RETURN;
      end
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

### rtl/stu_if.sv
// Valid/ready channel interfaces for source characters and tokens.
interface stu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_source;

  modport source (output valid, output char_code, output end_of_source, input ready);
  modport sink (input valid, input char_code, input end_of_source, output ready);
endinterface

interface stu_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [23:0] token_start;
  logic [23:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last_of_run, output ready);
endinterface

### rtl/stu_scan.sv
// Scanner state machine: takes one character per request, produces up to three tokens.
module stu_scan #(
  parameter int unsigned POSITION_BITS   = stu_pkg::POSITION_BITS_DEF,
  parameter int unsigned LONGEST_KEYWORD = stu_pkg::LONGEST_KEYWORD_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     char_code_i,
  input  logic           end_of_source_i,
  output stu_pkg::push_t push_o
);

  localparam int unsigned CNT_W = $clog2(LONGEST_KEYWORD + 2);
  localparam int unsigned IDX_W = $clog2(LONGEST_KEYWORD);
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [CNT_W-1:0] CNT_LK = CNT_W'(LONGEST_KEYWORD);

  typedef enum logic [8:0] {
    MODE_IDLE    = 9'b000000001,
    MODE_COMMENT = 9'b000000010,
    MODE_SLASH   = 9'b000000100,
    MODE_PAIR    = 9'b000001000,
    MODE_STRING  = 9'b000010000,
    MODE_NAME    = 9'b000100000,
    MODE_INT     = 9'b001000000,
    MODE_DOT     = 9'b010000000,
    MODE_FRAC    = 9'b100000000
  } scan_mode_e;

  scan_mode_e               mode_q, mode_d;
  logic [1:0]               pend_q, pend_d;
  logic [POSITION_BITS-1:0] tsp_q, tsp_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     fin_q, fin_d;
  logic [7:0]               prefix_q [LONGEST_KEYWORD];

  logic                     pf_we;
  logic [IDX_W-1:0]         pf_idx;

  logic [POSITION_BITS-1:0] p, nxt, dotpos;
  logic                     is_end;
  logic [8*stu_pkg::KW_MAX_LEN-1:0] kw_text;
  stu_pkg::kind_t           name_kind;

  function automatic logic [POSITION_BITS-1:0] span(input logic [POSITION_BITS-1:0] e,
                                                    input logic [POSITION_BITS-1:0] s);
    return (e >= s) ? e - s : '0;
  endfunction

  always_comb begin
    for (int i = 0; i < stu_pkg::KW_MAX_LEN; i++) begin
      kw_text[8*(stu_pkg::KW_MAX_LEN-1-i) +: 8] = prefix_q[i];
    end
  end

  assign name_kind = stu_pkg::kw_kind(kw_text, 4'(cnt_q));
  assign p      = pos_q;
  assign nxt    = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
  assign dotpos = (pos_q == '0) ? '0 : pos_q - 1'b1;
  assign is_end = end_of_source_i || (char_code_i == stu_pkg::CH_NUL);

  always_comb begin
    logic                     a_v, b_v, c_v, restart;
    stu_pkg::kind_t           a_kind, c_kind;
    logic [POSITION_BITS-1:0] a_len, a_start, c_start, c_len;
    stu_pkg::token_t          tok_a, tok_b, tok_c;
    logic [1:0]               n;

    mode_d  = mode_q;
    pend_d  = pend_q;
    tsp_d   = tsp_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    pf_we   = 1'b0;
    pf_idx  = cnt_q[IDX_W-1:0];
    a_v     = 1'b0;
    b_v     = 1'b0;
    c_v     = 1'b0;
    restart = 1'b0;
    a_kind  = stu_pkg::KIND_NUMBER;
    a_start = tsp_q;
    a_len   = span(p, tsp_q);
    c_kind  = stu_pkg::KIND_ERROR;
    c_start = p;
    c_len   = POSITION_BITS'(1);

    if (fire_i && !fin_q) begin
      if (is_end) begin
        // flush the pending token (a number and its dot from MODE_DOT), then end of file
        unique case (mode_q) inside
          MODE_SLASH: begin
            a_v = 1'b1; a_kind = stu_pkg::KIND_SLASH; a_len = POSITION_BITS'(1);
          end
          MODE_PAIR: begin
            a_v = 1'b1; a_kind = stu_pkg::pair_kind(pend_q); a_len = POSITION_BITS'(1);
          end
          MODE_STRING: begin
            a_v = 1'b1; a_kind = stu_pkg::KIND_ERROR;
          end
          MODE_NAME: begin
            a_v = 1'b1; a_kind = name_kind;
          end
          MODE_INT, MODE_FRAC: begin
            a_v = 1'b1;
          end
          MODE_DOT: begin
            a_v = 1'b1; b_v = 1'b1; a_len = span(dotpos, tsp_q);
          end
          default: ;
        endcase
        c_v     = 1'b1;
        c_kind  = stu_pkg::KIND_EOF;
        c_len   = '0;
        mode_d  = MODE_IDLE;
        tsp_d   = p;
        fin_d   = 1'b1;
      end else begin
        pos_d = nxt;
        unique case (mode_q)
          MODE_COMMENT: begin
            if (char_code_i == stu_pkg::CH_NL) mode_d = MODE_IDLE;
          end
          MODE_SLASH: begin
            if (char_code_i == stu_pkg::CH_SLASH) begin
              mode_d = MODE_COMMENT;
            end else begin
              a_v = 1'b1; a_kind = stu_pkg::KIND_SLASH; a_len = POSITION_BITS'(1);
              restart = 1'b1;
            end
          end
          MODE_PAIR: begin
            a_v = 1'b1;
            if (char_code_i == stu_pkg::CH_EQ) begin
              a_kind = stu_pkg::pair_kind(pend_q) + 1'b1;
              a_len  = span(nxt, tsp_q);
              mode_d = MODE_IDLE;
            end else begin
              a_kind  = stu_pkg::pair_kind(pend_q);
              a_len   = POSITION_BITS'(1);
              restart = 1'b1;
            end
          end
          MODE_STRING: begin
            if (char_code_i == stu_pkg::CH_QUOTE) begin
              a_v = 1'b1; a_kind = stu_pkg::KIND_STRING; a_len = span(nxt, tsp_q);
              mode_d = MODE_IDLE;
            end
          end
          MODE_NAME: begin
            if (stu_pkg::is_alpha(char_code_i) || stu_pkg::is_digit(char_code_i)) begin
              if (cnt_q < CNT_LK) pf_we = 1'b1;
              if (cnt_q <= CNT_LK) cnt_d = cnt_q + 1'b1;
            end else begin
              a_v = 1'b1; a_kind = name_kind;
              restart = 1'b1;
            end
          end
          MODE_INT: begin
            if (char_code_i == stu_pkg::CH_DOT) begin
              mode_d = MODE_DOT;
            end else if (!stu_pkg::is_digit(char_code_i)) begin
              a_v = 1'b1;
              restart = 1'b1;
            end
          end
          MODE_DOT: begin
            if (stu_pkg::is_digit(char_code_i)) begin
              mode_d = MODE_FRAC;
            end else begin
              // number without fraction, then the dot as its own token
              a_v = 1'b1; b_v = 1'b1; a_len = span(dotpos, tsp_q);
              restart = 1'b1;
            end
          end
          MODE_FRAC: begin
            if (!stu_pkg::is_digit(char_code_i)) begin
              a_v = 1'b1;
              restart = 1'b1;
            end
          end
          default: restart = 1'b1;
        endcase

        if (restart) begin
          mode_d = MODE_IDLE;
          tsp_d  = p;
          if (stu_pkg::is_space(char_code_i)) begin
            mode_d = MODE_IDLE;
          end else if (char_code_i == stu_pkg::CH_SLASH) begin
            mode_d = MODE_SLASH;
          end else if (stu_pkg::is_single(char_code_i)) begin
            c_v    = 1'b1;
            c_kind = stu_pkg::single_kind(char_code_i);
          end else if (stu_pkg::is_pair(char_code_i)) begin
            pend_d = stu_pkg::pair_code(char_code_i);
            mode_d = MODE_PAIR;
          end else if (char_code_i == stu_pkg::CH_QUOTE) begin
            mode_d = MODE_STRING;
          end else if (stu_pkg::is_alpha(char_code_i)) begin
            pf_we  = 1'b1;
            pf_idx = '0;
            cnt_d  = CNT_W'(1);
            mode_d = MODE_NAME;
          end else if (stu_pkg::is_digit(char_code_i)) begin
            mode_d = MODE_INT;
          end else begin
            c_v = 1'b1;
          end
        end
      end
    end

    tok_a.kind   = a_kind;
    tok_a.start  = stu_pkg::field_t'(a_start);
    tok_a.length = stu_pkg::field_t'(a_len);
    tok_a.last   = 1'b0;
    tok_b.kind   = stu_pkg::KIND_DOT;
    tok_b.start  = stu_pkg::field_t'(dotpos);
    tok_b.length = stu_pkg::field_t'(1);
    tok_b.last   = 1'b0;
    tok_c.kind   = c_kind;
    tok_c.start  = stu_pkg::field_t'(c_start);
    tok_c.length = stu_pkg::field_t'(c_len);
    tok_c.last   = 1'b0;

    // the dot token only ever follows a number, so packing is a simple select
    n = 2'(a_v) + 2'(b_v) + 2'(c_v);
    push_o.count  = n;
    push_o.tok[0] = a_v ? tok_a : tok_c;
    push_o.tok[1] = b_v ? tok_b : tok_c;
    push_o.tok[2] = tok_c;
    case (n)
      2'd1:    push_o.tok[0].last = 1'b1;
      2'd2:    push_o.tok[1].last = 1'b1;
      2'd3:    push_o.tok[2].last = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pend_q <= '0;
      tsp_q  <= '0;
      pos_q  <= '0;
      cnt_q  <= '0;
      fin_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      tsp_q  <= tsp_d;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pf_we) prefix_q[pf_idx] <= char_code_i;
  end

  // Once end of file has gone out nothing else may be produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> push_o.count == 2'd0)
    else $error("token produced after end of file");

  // An end-of-source request always yields end of file as its last token; checked here: fin_q set, pos_q held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !fin_q && is_end) |=> fin_q && $stable(pos_q))
    else $error("end of source not recorded");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q))
    else $error("scan mode not one-hot");

endmodule

### rtl/stu_tok_fifo.sv
// Small token buffer: takes up to three tokens per cycle, hands out one per cycle while ready_i is high.
module stu_tok_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stu_pkg::push_t  push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output stu_pkg::token_t tok_o
);

  localparam int unsigned DEPTH = stu_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = stu_pkg::FIFO_PTR_W;
  localparam int unsigned CNT_W = stu_pkg::FIFO_CNT_W;

  stu_pkg::token_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;
  // room for the largest burst one request can cause
  assign room_o  = (cnt_q <= CNT_W'(DEPTH - stu_pkg::MAX_PUSH));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    cnt_d    = cnt_q + CNT_W'(push_i.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < stu_pkg::MAX_PUSH; i++) begin
      if (2'(i) < push_i.count) mem_q[PTR_W'(wr_ptr_q + PTR_W'(i))] <= push_i.tok[i];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("token buffer count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> (CNT_W'(push_i.count) + cnt_q <= CNT_W'(DEPTH)))
    else $error("token buffer overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.count == 2'd0) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("token buffer count lost a pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("token buffer pointers disagree with count");

endmodule

### rtl/source_tokenizer_unit.sv
// Top level: streaming source tokenizer, one character request in, token requests out.
// The input request that completes a token writes it into the registered token buffer, which feeds out_o.
// Throughput: one character per cycle while in_i.ready is high; the scanner state updates with each request.
// in_i.ready falls while the four-entry token buffer has fewer than three free slots,
// which only multi-token bursts or a stalled consumer cause.
// Reset (rst_ni low, asynchronous) empties the buffer and returns the scanner to idle.
module source_tokenizer_unit #(
  parameter int unsigned POSITION_BITS   = stu_pkg::POSITION_BITS_DEF,
  parameter int unsigned LONGEST_KEYWORD = stu_pkg::LONGEST_KEYWORD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stu_in_if.sink     in_i,
  stu_out_if.source  out_o
);

  stu_pkg::push_t  push;
  stu_pkg::token_t tok;
  logic            room;
  logic            fire;

  assign in_i.ready = room;
  assign fire       = in_i.valid && room;

  stu_scan #(
    .POSITION_BITS   (POSITION_BITS),
    .LONGEST_KEYWORD (LONGEST_KEYWORD)
  ) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .char_code_i     (in_i.char_code),
    .end_of_source_i (in_i.end_of_source),
    .push_o          (push)
  );

  stu_tok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .tok_o   (tok)
  );

  assign out_o.token_kind   = tok.kind;
  assign out_o.token_start  = tok.start;
  assign out_o.token_length = tok.length;
  assign out_o.last_of_run  = tok.last;

endmodule

### verif/source_tokenizer_unit_tb.sv
// Self-checking testbench for source_tokenizer_unit: predicted token stream vs. DUT.
module source_tokenizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POS_W       = stu_pkg::POSITION_BITS_DEF;
  localparam int unsigned NAME_MAX    = stu_pkg::LONGEST_KEYWORD_DEF;
  localparam int unsigned STALL_LIMIT = 1000;

  typedef enum logic [8:0] {
    SCAN_IDLE    = 9'b000000001,
    SCAN_COMMENT = 9'b000000010,
    SCAN_SLASH   = 9'b000000100,
    SCAN_PAIR    = 9'b000001000,
    SCAN_STRING  = 9'b000010000,
    SCAN_NAME    = 9'b000100000,
    SCAN_INT     = 9'b001000000,
    SCAN_DOT     = 9'b010000000,
    SCAN_FRAC    = 9'b100000000
  } scan_e;

  logic clk_i;
  logic rst_ni;

  stu_in_if  in_if ();
  stu_out_if out_if ();

  source_tokenizer_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Scanner shadow state
  scan_e            scan_mode;
  logic [7:0]       scan_pair_char;
  logic [POS_W-1:0] scan_tok_begin;
  logic [POS_W-1:0] scan_pos;
  logic [47:0]      scan_word;
  int unsigned      scan_name_len;
  bit               scan_done;

  stu_pkg::token_t step_tokens[$];
  stu_pkg::token_t expected_tokens[$];
  logic [7:0]      src_text[$];
  stu_pkg::token_t seen_want;

  int unsigned mismatches;
  int unsigned tokens_seen;
  int unsigned items_sent;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;

  string kw_words [16] = '{"print", "nil", "fun", "class", "else", "false", "for", "if",
                           "return", "super", "this", "true", "var", "while", "and", "or"};

  // ---------------------------------------------------------------- predictor

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == stu_pkg::CH_US;
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int op_kind(input logic [7:0] c);
    case (c)
      stu_pkg::CH_LPAREN: return int'(stu_pkg::KIND_LPAREN);
      stu_pkg::CH_RPAREN: return int'(stu_pkg::KIND_RPAREN);
      stu_pkg::CH_LBRACE: return int'(stu_pkg::KIND_LBRACE);
      stu_pkg::CH_RBRACE: return int'(stu_pkg::KIND_RBRACE);
      stu_pkg::CH_COMMA:  return int'(stu_pkg::KIND_COMMA);
      stu_pkg::CH_DOT:    return int'(stu_pkg::KIND_DOT);
      stu_pkg::CH_MINUS:  return int'(stu_pkg::KIND_MINUS);
      stu_pkg::CH_PLUS:   return int'(stu_pkg::KIND_PLUS);
      stu_pkg::CH_SEMI:   return int'(stu_pkg::KIND_SEMICOLON);
      stu_pkg::CH_STAR:   return int'(stu_pkg::KIND_STAR);
      default:            return -1;
    endcase
  endfunction

  // kind of the starter alone; with '=' behind it the kind is one higher
  function automatic int pair_first_kind(input logic [7:0] c);
    case (c)
      stu_pkg::CH_BANG: return int'(stu_pkg::KIND_BANG);
      stu_pkg::CH_EQ:   return int'(stu_pkg::KIND_EQUAL);
      stu_pkg::CH_GT:   return int'(stu_pkg::KIND_GREATER);
      stu_pkg::CH_LESS: return int'(stu_pkg::KIND_LESS);
      default:          return -1;
    endcase
  endfunction

  // word holds the name right-aligned, zero above
  function automatic stu_pkg::kind_t keyword_kind(input logic [47:0] word);
    case (word)
      "print":  return stu_pkg::KIND_KW_PRINT;
      "nil":    return stu_pkg::KIND_KW_NIL;
      "fun":    return stu_pkg::KIND_KW_FUN;
      "class":  return stu_pkg::KIND_KW_CLASS;
      "else":   return stu_pkg::KIND_KW_ELSE;
      "false":  return stu_pkg::KIND_KW_FALSE;
      "for":    return stu_pkg::KIND_KW_FOR;
      "if":     return stu_pkg::KIND_KW_IF;
      "return": return stu_pkg::KIND_KW_RETURN;
      "super":  return stu_pkg::KIND_KW_SUPER;
      "this":   return stu_pkg::KIND_KW_THIS;
      "true":   return stu_pkg::KIND_KW_TRUE;
      "var":    return stu_pkg::KIND_KW_VAR;
      "while":  return stu_pkg::KIND_KW_WHILE;
      default:  return stu_pkg::KIND_IDENT;
    endcase
  endfunction

  function automatic void add_token(input stu_pkg::kind_t k, input logic [POS_W-1:0] s,
                                    input logic [POS_W-1:0] len);
    stu_pkg::token_t t;
    t.kind   = k;
    t.start  = stu_pkg::field_t'(s);
    t.length = stu_pkg::field_t'(len);
    t.last   = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic logic [POS_W-1:0] span_to(input logic [POS_W-1:0] end_pos);
    return (end_pos >= scan_tok_begin) ? end_pos - scan_tok_begin : '0;
  endfunction

  function automatic void close_name(input logic [POS_W-1:0] p);
    stu_pkg::kind_t k;
    k = stu_pkg::KIND_IDENT;
    if (scan_name_len <= NAME_MAX) k = keyword_kind(scan_word);
    add_token(k, scan_tok_begin, span_to(p));
  endfunction

  function automatic void close_number_dot(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] dot_pos;
    dot_pos = (p != '0) ? p - 1'b1 : '0;
    add_token(stu_pkg::KIND_NUMBER, scan_tok_begin, span_to(dot_pos));
    add_token(stu_pkg::KIND_DOT, dot_pos, POS_W'(1));
  endfunction

  function automatic void open_token(input logic [7:0] c, input logic [POS_W-1:0] p);
    scan_mode      = SCAN_IDLE;
    scan_tok_begin = p;
    if (c == stu_pkg::CH_SPACE || c == stu_pkg::CH_TAB || c == stu_pkg::CH_CR ||
        c == stu_pkg::CH_NL) return;
    if (c == stu_pkg::CH_SLASH) begin
      scan_mode = SCAN_SLASH;
    end else if (op_kind(c) >= 0) begin
      add_token(stu_pkg::kind_t'(op_kind(c)), p, POS_W'(1));
    end else if (pair_first_kind(c) >= 0) begin
      scan_pair_char = c;
      scan_mode      = SCAN_PAIR;
    end else if (c == stu_pkg::CH_QUOTE) begin
      scan_mode = SCAN_STRING;
    end else if (is_letter(c)) begin
      scan_word     = {40'd0, c};
      scan_name_len = 1;
      scan_mode     = SCAN_NAME;
    end else if (is_num(c)) begin
      scan_mode = SCAN_INT;
    end else begin
      add_token(stu_pkg::KIND_ERROR, p, POS_W'(1));
    end
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] nxt;
    p   = scan_pos;
    nxt = (p != '1) ? p + 1'b1 : p;
    case (scan_mode)
      SCAN_COMMENT: if (c == stu_pkg::CH_NL) scan_mode = SCAN_IDLE;
      SCAN_SLASH: begin
        if (c == stu_pkg::CH_SLASH) begin
          scan_mode = SCAN_COMMENT;
        end else begin
          add_token(stu_pkg::KIND_SLASH, scan_tok_begin, POS_W'(1));
          open_token(c, p);
        end
      end
      SCAN_PAIR: begin
        if (c == stu_pkg::CH_EQ) begin
          add_token(stu_pkg::kind_t'(pair_first_kind(scan_pair_char) + 1), scan_tok_begin,
                    span_to(nxt));
          scan_mode = SCAN_IDLE;
        end else begin
          add_token(stu_pkg::kind_t'(pair_first_kind(scan_pair_char)), scan_tok_begin,
                    POS_W'(1));
          open_token(c, p);
        end
      end
      SCAN_STRING: begin
        if (c == stu_pkg::CH_QUOTE) begin
          add_token(stu_pkg::KIND_STRING, scan_tok_begin, span_to(nxt));
          scan_mode = SCAN_IDLE;
        end
      end
      SCAN_NAME: begin
        if (is_letter(c) || is_num(c)) begin
          if (scan_name_len < NAME_MAX) scan_word = {scan_word[39:0], c};
          if (scan_name_len <= NAME_MAX) scan_name_len++;
        end else begin
          close_name(p);
          open_token(c, p);
        end
      end
      SCAN_INT: begin
        if (c == stu_pkg::CH_DOT) begin
          scan_mode = SCAN_DOT;
        end else if (!is_num(c)) begin
          add_token(stu_pkg::KIND_NUMBER, scan_tok_begin, span_to(p));
          open_token(c, p);
        end
      end
      SCAN_DOT: begin
        if (is_num(c)) begin
          scan_mode = SCAN_FRAC;
        end else begin
          close_number_dot(p);
          open_token(c, p);
        end
      end
      SCAN_FRAC: begin
        if (!is_num(c)) begin
          add_token(stu_pkg::KIND_NUMBER, scan_tok_begin, span_to(p));
          open_token(c, p);
        end
      end
      default: open_token(c, p);
    endcase
    scan_pos = nxt;
  endfunction

  function automatic void scan_end();
    logic [POS_W-1:0] p;
    p = scan_pos;
    case (scan_mode) inside
      SCAN_SLASH:  add_token(stu_pkg::KIND_SLASH, scan_tok_begin, POS_W'(1));
      SCAN_PAIR:   add_token(stu_pkg::kind_t'(pair_first_kind(scan_pair_char)),
                             scan_tok_begin, POS_W'(1));
      SCAN_STRING: add_token(stu_pkg::KIND_ERROR, scan_tok_begin, span_to(p));
      SCAN_NAME:   close_name(p);
      SCAN_INT, SCAN_FRAC: add_token(stu_pkg::KIND_NUMBER, scan_tok_begin, span_to(p));
      SCAN_DOT:    close_number_dot(p);
      default: ;
    endcase
    scan_mode      = SCAN_IDLE;
    scan_tok_begin = p;
    add_token(stu_pkg::KIND_EOF, p, '0);
    scan_done = 1'b1;
  endfunction

  function automatic void predict_tokens(input logic [7:0] c, input logic eos);
    stu_pkg::token_t t;
    step_tokens.delete();
    if (scan_done) return;
    if (eos || c == stu_pkg::CH_NUL) scan_end();
    else scan_char(c);
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    while (step_tokens.size() > 0) begin
      t = step_tokens.pop_front();
      expected_tokens.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------- driving

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_char(input logic [7:0] c, input logic eos);
    bit took;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.char_code     <= c;
    in_if.end_of_source <= eos;
    do begin
      @(negedge clk_i);
      took = in_if.ready;
      @(posedge clk_i);
    end while (!took);
    predict_tokens(c, eos);
    items_sent++;
  endtask

  task automatic send_text();
    while (src_text.size() > 0) send_char(src_text.pop_front(), 1'b0);
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_letter();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(r) + "a";
    if (r < 52) return 8'(r - 26) + "A";
    return stu_pkg::CH_US;
  endfunction

  function automatic logic [7:0] pick_name_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 9)) + "0";
    return pick_letter();
  endfunction

  // any byte but the end marker and the given terminator
  function automatic logic [7:0] pick_body_byte(input logic [7:0] stop);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == stop);
    return b;
  endfunction

  function automatic void queue_digits(input int unsigned n);
    repeat (n) src_text.push_back(8'($urandom_range(0, 9)) + "0");
  endfunction

  // one well-formed lexeme most of the time, raw noise now and then
  function automatic void queue_lexeme();
    logic [7:0] ops [14];
    ops = '{stu_pkg::CH_LPAREN, stu_pkg::CH_RPAREN, stu_pkg::CH_LBRACE, stu_pkg::CH_RBRACE,
            stu_pkg::CH_COMMA, stu_pkg::CH_DOT, stu_pkg::CH_MINUS, stu_pkg::CH_PLUS,
            stu_pkg::CH_SEMI, stu_pkg::CH_STAR, stu_pkg::CH_BANG, stu_pkg::CH_EQ,
            stu_pkg::CH_GT, stu_pkg::CH_LESS};
    case ($urandom_range(0, 11)) inside
      0, 1, 2: begin
        push_text(kw_words[$urandom_range(0, 15)]);
        if ($urandom_range(0, 4) == 0) src_text.push_back(pick_name_char());
      end
      3, 4: begin
        src_text.push_back(pick_letter());
        repeat ($urandom_range(0, 9)) src_text.push_back(pick_name_char());
      end
      5, 6: begin
        queue_digits($urandom_range(1, 3));
        case ($urandom_range(0, 5)) inside
          0, 1: begin
            src_text.push_back(stu_pkg::CH_DOT);
            queue_digits($urandom_range(1, 2));
          end
          2: src_text.push_back(stu_pkg::CH_DOT);
          default: ;
        endcase
      end
      7: begin
        src_text.push_back(stu_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 5)) src_text.push_back(pick_body_byte(stu_pkg::CH_QUOTE));
        src_text.push_back(stu_pkg::CH_QUOTE);
      end
      8: begin
        push_text("//");
        repeat ($urandom_range(0, 5)) src_text.push_back(pick_body_byte(stu_pkg::CH_NL));
        src_text.push_back(stu_pkg::CH_NL);
      end
      9, 10: begin
        src_text.push_back(ops[$urandom_range(0, 13)]);
        if ($urandom_range(0, 2) == 0) src_text.push_back(stu_pkg::CH_EQ);
      end
      default: src_text.push_back(8'($urandom_range(1, 255)));
    endcase
    case ($urandom_range(0, 7)) inside
      0, 1: src_text.push_back(stu_pkg::CH_SPACE);
      2:    src_text.push_back(stu_pkg::CH_NL);
      3:    src_text.push_back(stu_pkg::CH_TAB);
      4:    src_text.push_back(stu_pkg::CH_CR);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input stu_pkg::field_t got,
                                 input stu_pkg::field_t want);
    $display("[%0t] token %0d: %s got %0d expected %0d", $realtime, tokens_seen, what,
             got, want);
    mismatches++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected token, kind", stu_pkg::field_t'(out_if.token_kind), '0);
      end else begin
        seen_want = expected_tokens.pop_front();
        if (out_if.token_kind !== seen_want.kind)
          report_mismatch("kind", stu_pkg::field_t'(out_if.token_kind),
                          stu_pkg::field_t'(seen_want.kind));
        if (out_if.token_start !== seen_want.start)
          report_mismatch("start", out_if.token_start, seen_want.start);
        if (out_if.token_length !== seen_want.length)
          report_mismatch("length", out_if.token_length, seen_want.length);
        if (out_if.last_of_run !== seen_want.last)
          report_mismatch("last", stu_pkg::field_t'(out_if.last_of_run),
                          stu_pkg::field_t'(seen_want.last));
      end
      tokens_seen++;
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(negedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // sink side back-pressure in random bursts
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- tests

  // every single-char and paired operator, a three-token burst, unknown bytes
  task automatic test_directed_tokens();
    gap_pct   = 20;
    stall_pct = 20;
    push_text("(){},.-+;*");
    push_text("!=><<===>==!/7.;");
    src_text.push_back(8'hFF);
    src_text.push_back(8'h01);
    send_text();
  endtask

  task automatic test_random_source(input int unsigned count, input int unsigned idle_pct);
    int unsigned goal;
    goal      = items_sent + count;
    gap_pct   = idle_pct;
    stall_pct = idle_pct;
    while (items_sent < goal) begin
      queue_lexeme();
      send_text();
    end
  endtask

  // hold the sender until the token stream has fully drained
  task automatic test_drain_pause();
    in_if.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // leave some token open, then close the source
  task automatic test_end_of_source();
    gap_pct   = 0;
    stall_pct = 0;
    src_text.push_back(stu_pkg::CH_SPACE);
    case ($urandom_range(0, 6))
      0: push_text("\"open str");
      1: push_text("//open note");
      2: src_text.push_back(stu_pkg::CH_LESS);
      3: push_text("whil");
      4: push_text("42.");
      5: src_text.push_back(stu_pkg::CH_SLASH);
      default: ;
    endcase
    send_text();
    if ($urandom_range(0, 1) == 1) send_char(8'($urandom_range(0, 255)), 1'b1);
    else send_char(stu_pkg::CH_NUL, 1'b0);
  endtask

  task automatic test_after_end();
    send_char(stu_pkg::CH_NUL, 1'b0);
    send_char(8'hA5, 1'b1);
    repeat (6) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    in_if.valid         <= 1'b0;
    in_if.char_code     <= stu_pkg::CH_NUL;
    in_if.end_of_source <= 1'b0;
    rst_ni         = 1'b0;
    scan_mode      = SCAN_IDLE;
    scan_pair_char = '0;
    scan_tok_begin = '0;
    scan_pos       = '0;
    scan_word      = '0;
    scan_name_len  = 0;
    scan_done      = 1'b0;
    mismatches     = 0;
    tokens_seen    = 0;
    items_sent     = 0;
    gap_pct        = 0;
    stall_pct      = 0;
    quiet_cycles   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_tokens();
    test_random_source(120, 25);
    test_random_source(60, 0);
    test_random_source(120, 35);
    test_drain_pause();
    test_random_source(100, 0);
    test_end_of_source();
    test_after_end();

    in_if.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### source_tokenizer_unit.f
rtl/stu_pkg.sv
rtl/stu_if.sv
rtl/stu_scan.sv
rtl/stu_tok_fifo.sv
rtl/source_tokenizer_unit.sv
verif/source_tokenizer_unit_tb.sv
